### hw/rtl/lbca_pkg.sv
// Shared types, constants and bar-pattern functions for the LED-bar charge animator.
package lbca_pkg;

  // Manager state codes.
  localparam logic [7:0] ST_CHARGING  = 8'h02;
  localparam logic [7:0] ST_BLINK     = 8'h03;
  localparam logic [7:0] ST_OFF_A     = 8'h05;
  localparam logic [7:0] ST_OFF_B     = 8'h06;
  localparam logic [7:0] ST_FAULT_LO  = 8'h07;
  localparam logic [7:0] ST_FAULT_HI  = 8'h1b;
  localparam logic [7:0] ST_FAULT_ALT = 8'hff;

  // Bar patterns.
  localparam logic [7:0] BAR_FAULT = 8'hfa;
  localparam logic [7:0] BAR_OFF   = 8'h00;
  localparam logic [7:0] BAR_SEG1  = 8'h84;
  localparam logic [7:0] BAR_SEG2  = 8'hc4;
  localparam logic [7:0] BAR_SEG3  = 8'he4;
  localparam logic [7:0] BAR_SEG4  = 8'hf4;
  localparam logic [7:0] BAR_FULL  = 8'hfc;
  localparam logic [7:0] LEVEL_MASK = 8'hfe;

  // Thresholds.
  localparam logic [7:0]  SOC_STEADY    = 8'd95;
  localparam logic [7:0]  SOC_BAND_E    = 8'd90;
  localparam logic [7:0]  SOC_BAND_D    = 8'd75;
  localparam logic [7:0]  SOC_BAND_C    = 8'd50;
  localparam logic [7:0]  SOC_BAND_B    = 8'd25;
  localparam logic [31:0] BLINK_START   = 32'd200;
  localparam logic [31:0] METRIC_STEADY = 32'd299;
  localparam logic [4:0]  WRAP_NORMAL   = 5'd23;
  localparam logic [4:0]  WRAP_BAND_D   = 5'd24;
  localparam logic [4:0]  PHASE_DIM     = 5'd12;

  // Charge band used by the fill-up animation.
  typedef enum logic [2:0] {
    BAND_A,
    BAND_B,
    BAND_C,
    BAND_D,
    BAND_E
  } band_t;

  // One input item.
  typedef struct packed {
    logic [7:0]  state_code;
    logic [7:0]  soc_percent;
    logic        mode_flag;
    logic [31:0] elapsed_count;
    logic [31:0] charge_metric;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] led_byte;
    logic       send;
    logic       clear_mode_flag;
  } result_t;

  // Steady bar for a charge percentage.
  function automatic logic [7:0] full_bar(input logic [7:0] soc);
    logic [7:0] bar;
    if (soc >= SOC_BAND_E) bar = BAR_FULL;
    else if (soc >= SOC_BAND_D) bar = BAR_SEG4;
    else if (soc >= SOC_BAND_C) bar = BAR_SEG3;
    else if (soc >= SOC_BAND_B) bar = BAR_SEG2;
    else if (soc != 8'd0) bar = BAR_SEG1;
    else bar = BAR_OFF;
    return bar;
  endfunction

  // Bar one segment dimmer than the steady bar.
  function automatic logic [7:0] dim_bar(input logic [7:0] soc);
    logic [7:0] bar;
    if (soc >= SOC_BAND_E) bar = BAR_SEG4;
    else if (soc >= SOC_BAND_D) bar = BAR_SEG3;
    else if (soc >= SOC_BAND_C) bar = BAR_SEG2;
    else if (soc >= SOC_BAND_B) bar = BAR_SEG1;
    else bar = BAR_OFF;
    return bar;
  endfunction

endpackage

### hw/rtl/lbca_ifs.sv
// Valid/ready channel interfaces for the input and result items.
interface lbca_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  state_code;
  logic [7:0]  soc_percent;
  logic        mode_flag;
  logic [31:0] elapsed_count;
  logic [31:0] charge_metric;

  modport source (
    output valid, state_code, soc_percent, mode_flag, elapsed_count, charge_metric,
    input  ready
  );
  modport sink (
    input  valid, state_code, soc_percent, mode_flag, elapsed_count, charge_metric,
    output ready
  );
endinterface

interface lbca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_byte;
  logic       send;
  logic       clear_mode_flag;

  modport source (output valid, led_byte, send, clear_mode_flag, input ready);
  modport sink (input valid, led_byte, send, clear_mode_flag, output ready);
endinterface

### hw/rtl/lbca_core.sv
// Animation state and per-tick update logic: blink counter, bar level, last sent byte.
module lbca_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lbca_pkg::item_t   item,
  output lbca_pkg::result_t result
);
  import lbca_pkg::*;

  logic [4:0] blink_counter_r, blink_counter_nxt;
  logic [7:0] bar_level_r, bar_level_nxt;
  logic [7:0] last_sent_r, last_sent_nxt;

  logic       is_fault;
  logic       is_off;
  logic       steady_full;
  band_t      band;
  logic [4:0] step;
  logic [4:0] wrap_limit;
  logic [4:0] advanced;
  logic [7:0] fill_level;
  logic       mode_bit;
  logic [7:0] byte_out;

  // Decode the state and the charge band.
  always_comb begin
    is_fault = ((item.state_code >= ST_FAULT_LO) && (item.state_code <= ST_FAULT_HI)) ||
               (item.state_code == ST_FAULT_ALT);
    is_off = (item.state_code == ST_OFF_A) || (item.state_code == ST_OFF_B);
    steady_full = (item.soc_percent >= SOC_STEADY) && (item.charge_metric <= METRIC_STEADY);
    if (item.soc_percent >= SOC_BAND_E) band = BAND_E;
    else if (item.soc_percent >= SOC_BAND_D) band = BAND_D;
    else if (item.soc_percent >= SOC_BAND_C) band = BAND_C;
    else if (item.soc_percent >= SOC_BAND_B) band = BAND_B;
    else band = BAND_A;
  end

  // Next phase of the counter; the 75..89 band runs one phase longer when charging.
  always_comb begin
    wrap_limit = ((item.state_code == ST_CHARGING) && (band == BAND_D)) ?
                 WRAP_BAND_D : WRAP_NORMAL;
    step = blink_counter_r + 5'd1;
    advanced = (step > wrap_limit) ? 5'd0 : step;
  end

  // Fill-up level for the current phase; between steps the level holds.
  always_comb begin
    fill_level = bar_level_r;
    unique case (band)
      BAND_A: begin
        unique case (blink_counter_r)
          5'd0:    fill_level = BAR_OFF;
          5'd12:   fill_level = BAR_SEG1;
          default: fill_level = bar_level_r;
        endcase
      end
      BAND_B: begin
        unique case (blink_counter_r)
          5'd0:    fill_level = BAR_OFF;
          5'd8:    fill_level = BAR_SEG1;
          5'd16:   fill_level = BAR_SEG2;
          default: fill_level = bar_level_r;
        endcase
      end
      BAND_C: begin
        unique case (blink_counter_r)
          5'd0:    fill_level = BAR_OFF;
          5'd6:    fill_level = BAR_SEG1;
          5'd12:   fill_level = BAR_SEG2;
          5'd18:   fill_level = BAR_SEG3;
          default: fill_level = bar_level_r;
        endcase
      end
      BAND_D: begin
        unique case (blink_counter_r)
          5'd0:    fill_level = BAR_OFF;
          5'd5:    fill_level = BAR_SEG1;
          5'd10:   fill_level = BAR_SEG2;
          5'd15:   fill_level = BAR_SEG3;
          5'd20:   fill_level = BAR_SEG4;
          default: fill_level = bar_level_r;
        endcase
      end
      BAND_E: begin
        unique case (blink_counter_r)
          5'd0:    fill_level = BAR_OFF;
          5'd4:    fill_level = BAR_SEG1;
          5'd8:    fill_level = BAR_SEG2;
          5'd12:   fill_level = BAR_SEG3;
          5'd16:   fill_level = BAR_SEG4;
          5'd20:   fill_level = BAR_FULL;
          default: fill_level = bar_level_r;
        endcase
      end
      default: fill_level = bar_level_r;
    endcase
  end

  // Bar level and counter update for this tick.
  always_comb begin
    bar_level_nxt = full_bar(item.soc_percent);
    blink_counter_nxt = 5'd0;
    mode_bit = item.mode_flag;
    if (is_fault) begin
      bar_level_nxt = BAR_FAULT;
    end else if (item.state_code == ST_BLINK) begin
      if (item.elapsed_count >= BLINK_START) begin
        if (blink_counter_r == 5'd0) bar_level_nxt = full_bar(item.soc_percent);
        else if (blink_counter_r == PHASE_DIM) bar_level_nxt = dim_bar(item.soc_percent);
        else bar_level_nxt = bar_level_r;
        blink_counter_nxt = advanced;
      end
    end else if (item.state_code == ST_CHARGING) begin
      if (steady_full) begin
        bar_level_nxt = BAR_FULL;
      end else begin
        bar_level_nxt = fill_level;
        blink_counter_nxt = advanced;
      end
    end else if (is_off) begin
      bar_level_nxt = BAR_OFF;
      mode_bit = 1'b0;
    end
    byte_out = (bar_level_nxt & LEVEL_MASK) | {7'd0, mode_bit};
    last_sent_nxt = byte_out;
  end

  assign result.led_byte        = byte_out;
  assign result.send            = (byte_out != last_sent_r);
  assign result.clear_mode_flag = is_off;

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_counter_r <= 5'd0;
      bar_level_r     <= 8'd0;
      last_sent_r     <= 8'd0;
    end else if (fire) begin
      blink_counter_r <= blink_counter_nxt;
      bar_level_r     <= bar_level_nxt;
      last_sent_r     <= last_sent_nxt;
    end
  end

endmodule

### hw/rtl/led_bar_charge_animator.sv
// LED-bar charge animator: one update item in, one LED-bar item out, one item per cycle when the output does not stall.
// Accepts one update item per clock cycle unless the output stalls. Each item is captured in an input register,
// its bar level, send strobe and mode-clear request are computed combinationally against
// the animation state, and the result is held in an output register: the result is offered
// from the output register, which loads it once that register is empty or its last result is taken.
// While a finished result waits to be taken, the input register still accepts
// one more item, and input stalls only once that item is held as well.
module led_bar_charge_animator (
  input  logic       clk,
  input  logic       rst_n,
  lbca_in_if.sink    in_item,
  lbca_out_if.source out_item
);
  import lbca_pkg::*;

  logic    in_valid_r;
  item_t   in_data_r;
  logic    out_valid_r;
  result_t out_data_r;
  result_t result;
  logic    advance;
  logic    fire;

  // Pipeline control: the output register advances when empty or taken.
  assign advance = !out_valid_r || out_item.ready;
  assign fire = in_valid_r && advance;
  assign in_item.ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_item.valid && in_item.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      in_data_r.state_code    <= in_item.state_code;
      in_data_r.soc_percent   <= in_item.soc_percent;
      in_data_r.mode_flag     <= in_item.mode_flag;
      in_data_r.elapsed_count <= in_item.elapsed_count;
      in_data_r.charge_metric <= in_item.charge_metric;
    end
  end

  // Update logic and animation state.
  lbca_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_data_r),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.led_byte        = out_data_r.led_byte;
  assign out_item.send            = out_data_r.send;
  assign out_item.clear_mode_flag = out_data_r.clear_mode_flag;

endmodule
